### sv/nmea_pkg.sv
package nmea_pkg;

  // kind of a result transaction, carried on tuser
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_FIELD   = 2'd1,
    KIND_SEP     = 2'd2,
    KIND_VERDICT = 2'd3
  } item_kind_e;

  // end-of-line verdict
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_DOLLAR    = 3'd1,
    ST_CKS_MISMATCH = 3'd2,
    ST_TOO_LONG     = 3'd3,
    ST_TOO_MANY     = 3'd4
  } line_status_e;

  // register index on the apb port (paddr[2])
  localparam logic REG_MAX_PAYLOAD = 1'b0;

  // reset value of the payload length limit
  localparam logic [7:0] MAX_PAYLOAD_RESET = 8'd80;

  // ascii characters of interest
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // one result item
  typedef struct packed {
    item_kind_e   kind;
    logic [7:0]   char_value;
    logic [4:0]   field_number;
    logic [7:0]   char_offset;
    line_status_e line_status;
    logic         checksum_present;
    logic [7:0]   computed_checksum;
    logic [5:0]   field_total;
    logic         last;
  } result_t;

  // hex digit decode: bit 4 is valid, bits 3:0 the value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

### sv/nmea_sentence_parser_core.sv
// channel   | dir | handshake                    | payload
// ----------+-----+------------------------------+-------------------------------------------
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | tdata[7:0] line_byte
// m_axis    | out | m_axis_tvalid/m_axis_tready  | tdata char..total, tuser kind, tlast last
// apb       | in  | psel/penable/pwrite, pready  | reg 0 at 0x0: max_payload_length[7:0]
//
// one input byte per cycle unless stalled; a body byte releases the oldest of four held-back bytes
// at newline the input stalls while up to four released bytes and then the verdict go out,
// one result per cycle through the shared release logic while the output queue has room
// results go through a two-entry output queue, so the input keeps flowing while one waits
// asynchronous active-low reset clears all control state and sets the limit to 80
module nmea_sentence_parser_core #(
  parameter int TALKER_LENGTH   = 2,
  parameter int SENTENCE_LENGTH = 3,
  parameter int MAX_FIELDS      = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
  // stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_value, [12:8] field_number, [20:13] char_offset, [23:21] line_status,
  // [24] checksum_present, [32:25] computed_checksum, [38:33] field_total, [39] zero
  output logic [39:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
  output logic        m_axis_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import nmea_pkg::*;

  localparam int HDR_LEN = TALKER_LENGTH + SENTENCE_LENGTH;
  localparam int HPW     = $clog2(HDR_LEN + 1);
  localparam int CFW     = $clog2(MAX_FIELDS);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_BODY    = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;
  localparam logic [1:0] PH_FLUSH   = 2'd3;

  logic [1:0]     phase_q, phase_d;
  logic [7:0]     hb_q [4];
  logic [7:0]     hb_d [4];
  logic [2:0]     hb_cnt_q, hb_cnt_d;
  logic [7:0]     xor_q, xor_d;
  logic [7:0]     pcnt_q, pcnt_d;
  logic [HPW-1:0] hp_q, hp_d;
  logic [CFW-1:0] cf_q, cf_d;
  logic [7:0]     fco_q, fco_d;
  line_status_e   err_q, err_d;
  logic [7:0]     max_len_q;
  logic [2:0]     fl_left_q, fl_left_d;
  logic           cks_present_q, cks_present_d;
  logic           cks_ok_q, cks_ok_d;
  logic [7:0]     cks_val_q, cks_val_d;

  result_t        fifo_q [2];
  logic [1:0]     fcnt_q;
  logic           push_ok, pop, push, wr_slot;
  result_t        push_data;
  logic           accept;

  // release of the oldest held-back byte
  logic [7:0]     rel_b, rel_xor, rel_pcnt, rel_fco;
  line_status_e   rel_err;
  logic [HPW-1:0] rel_hp;
  logic [CFW-1:0] rel_cf;
  result_t        rel_res;

  always_comb begin
    rel_b   = hb_q[0];
    rel_xor = xor_q ^ rel_b;
    rel_err = err_q;
    if (pcnt_q >= max_len_q && err_q == ST_OK) begin
      rel_err = ST_TOO_LONG;
    end
    rel_pcnt = (pcnt_q == 8'hFF) ? pcnt_q : pcnt_q + 8'd1;
    rel_hp   = hp_q;
    rel_cf   = cf_q;
    rel_fco  = fco_q;
    rel_res  = '0;
    rel_res.char_value = rel_b;
    if (hp_q < HPW'(HDR_LEN)) begin
      rel_res.kind        = KIND_HEADER;
      rel_res.char_offset = 8'(hp_q);
      rel_hp              = hp_q + 1'b1;
    end else if (rel_b == CH_COMMA) begin
      if (cf_q == CFW'(MAX_FIELDS - 1)) begin
        if (rel_err == ST_OK) begin
          rel_err = ST_TOO_MANY;
        end
      end else begin
        rel_cf = cf_q + 1'b1;
      end
      rel_fco              = 8'd0;
      rel_res.kind         = KIND_SEP;
      rel_res.field_number = 5'(rel_cf);
    end else begin
      rel_res.kind         = KIND_FIELD;
      rel_res.field_number = 5'(cf_q);
      rel_res.char_offset  = fco_q;
      rel_fco              = (fco_q == 8'hFF) ? fco_q : fco_q + 8'd1;
    end
  end

  // newline: strip cr, find a star checksum
  logic [2:0] nl_n0, nl_n1, nl_len;
  logic       nl_star;
  logic [4:0] nl_hi, nl_lo;

  always_comb begin
    nl_n0 = hb_cnt_q;
    nl_n1 = nl_n0;
    if (nl_n0 != 3'd0 && hb_q[2'(nl_n0 - 3'd1)] == CH_CR) begin
      nl_n1 = nl_n0 - 3'd1;
    end
    nl_star = (nl_n1 >= 3'd3) && (hb_q[2'(nl_n1 - 3'd3)] == CH_STAR);
    nl_hi   = hex_digit(hb_q[2'(nl_n1 - 3'd2)]);
    nl_lo   = hex_digit(hb_q[2'(nl_n1 - 3'd1)]);
    nl_len  = nl_star ? nl_n1 - 3'd3 : nl_n1;
  end

  // verdict items
  result_t verdict_res, nodollar_res;
  logic    cks_match;

  always_comb begin
    cks_match = !cks_present_q || (cks_ok_q && cks_val_q == xor_q);
    verdict_res                   = '0;
    verdict_res.kind              = KIND_VERDICT;
    verdict_res.line_status       = cks_match ? err_q : ST_CKS_MISMATCH;
    verdict_res.checksum_present  = cks_present_q;
    verdict_res.computed_checksum = xor_q;
    verdict_res.field_total       = (pcnt_q > 8'(HDR_LEN)) ?
                                    6'({1'b0, cf_q} + 1'b1) : 6'd0;
    verdict_res.last              = 1'b1;
    nodollar_res                  = '0;
    nodollar_res.kind             = KIND_VERDICT;
    nodollar_res.line_status      = ST_NO_DOLLAR;
    nodollar_res.last             = 1'b1;
  end

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_ok       = (fcnt_q != 2'd2);
  assign s_axis_tready = push_ok && (phase_q != PH_FLUSH);

  // line sequencing
  always_comb begin
    logic clear_line;
    logic take_rel;
    clear_line    = 1'b0;
    take_rel      = 1'b0;
    phase_d       = phase_q;
    hb_d          = hb_q;
    hb_cnt_d      = hb_cnt_q;
    xor_d         = xor_q;
    pcnt_d        = pcnt_q;
    hp_d          = hp_q;
    cf_d          = cf_q;
    fco_d         = fco_q;
    err_d         = err_q;
    fl_left_d     = fl_left_q;
    cks_present_d = cks_present_q;
    cks_ok_d      = cks_ok_q;
    cks_val_d     = cks_val_q;
    push          = 1'b0;
    push_data     = rel_res;

    unique case (phase_q)
      PH_IDLE: begin
        if (accept) begin
          if (s_axis_tdata == CH_DOLLAR) begin
            clear_line = 1'b1;
            phase_d    = PH_BODY;
          end else if (s_axis_tdata == CH_LF) begin
            push      = 1'b1;
            push_data = nodollar_res;
          end else begin
            phase_d = PH_DISCARD;
          end
        end
      end
      PH_DISCARD: begin
        if (accept && s_axis_tdata == CH_LF) begin
          push       = 1'b1;
          push_data  = nodollar_res;
          clear_line = 1'b1;
          phase_d    = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (accept) begin
          if (s_axis_tdata != CH_LF) begin
            if (hb_cnt_q == 3'd4) begin
              take_rel = 1'b1;
              hb_d[3]  = s_axis_tdata;
            end else begin
              hb_d[2'(hb_cnt_q)] = s_axis_tdata;
              hb_cnt_d           = hb_cnt_q + 3'd1;
            end
          end else begin
            fl_left_d     = nl_len;
            cks_present_d = nl_star;
            cks_ok_d      = nl_hi[4] & nl_lo[4];
            cks_val_d     = {nl_hi[3:0], nl_lo[3:0]};
            phase_d       = PH_FLUSH;
          end
        end
      end
      PH_FLUSH: begin
        if (push_ok) begin
          if (fl_left_q != 3'd0) begin
            take_rel  = 1'b1;
            fl_left_d = fl_left_q - 3'd1;
          end else begin
            push       = 1'b1;
            push_data  = verdict_res;
            clear_line = 1'b1;
            phase_d    = PH_IDLE;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // shift out the oldest byte as payload
    if (take_rel) begin
      push    = 1'b1;
      xor_d   = rel_xor;
      pcnt_d  = rel_pcnt;
      hp_d    = rel_hp;
      cf_d    = rel_cf;
      fco_d   = rel_fco;
      err_d   = rel_err;
      hb_d[0] = hb_q[1];
      hb_d[1] = hb_q[2];
      hb_d[2] = hb_q[3];
    end

    if (clear_line) begin
      for (int i = 0; i < 4; i++) begin
        hb_d[i] = 8'd0;
      end
      hb_cnt_d = 3'd0;
      xor_d    = 8'd0;
      pcnt_d   = 8'd0;
      hp_d     = '0;
      cf_d     = '0;
      fco_d    = 8'd0;
      err_d    = ST_OK;
    end
  end

  // line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      for (int i = 0; i < 4; i++) begin
        hb_q[i] <= 8'd0;
      end
      hb_cnt_q      <= 3'd0;
      xor_q         <= 8'd0;
      pcnt_q        <= 8'd0;
      hp_q          <= '0;
      cf_q          <= '0;
      fco_q         <= 8'd0;
      err_q         <= ST_OK;
      fl_left_q     <= 3'd0;
      cks_present_q <= 1'b0;
      cks_ok_q      <= 1'b0;
      cks_val_q     <= 8'd0;
    end else begin
      phase_q       <= phase_d;
      hb_q          <= hb_d;
      hb_cnt_q      <= hb_cnt_d;
      xor_q         <= xor_d;
      pcnt_q        <= pcnt_d;
      hp_q          <= hp_d;
      cf_q          <= cf_d;
      fco_q         <= fco_d;
      err_q         <= err_d;
      fl_left_q     <= fl_left_d;
      cks_present_q <= cks_present_d;
      cks_ok_q      <= cks_ok_d;
      cks_val_q     <= cks_val_d;
    end
  end

  // two-entry output queue
  assign pop     = (fcnt_q != 2'd0) && m_axis_tready;
  assign wr_slot = (fcnt_q == 2'd1) && !pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcnt_q <= 2'd0;
    end else begin
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // head entry takes a new item into an empty head, else moves up on a pop
  always_ff @(posedge clk_i) begin
    if (push && !wr_slot) begin
      fifo_q[0] <= push_data;
    end else if (pop) begin
      fifo_q[0] <= fifo_q[1];
    end
    if (push && wr_slot) begin
      fifo_q[1] <= push_data;
    end
  end

  assign m_axis_tvalid = (fcnt_q != 2'd0);
  assign m_axis_tuser  = fifo_q[0].kind;
  assign m_axis_tlast  = fifo_q[0].last;
  assign m_axis_tdata  = {1'b0,
                          fifo_q[0].field_total,
                          fifo_q[0].computed_checksum,
                          fifo_q[0].checksum_present,
                          fifo_q[0].line_status,
                          fifo_q[0].char_offset,
                          fifo_q[0].field_number,
                          fifo_q[0].char_value};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_PAYLOAD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_PAYLOAD) begin
      max_len_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_PAYLOAD) ? {24'd0, max_len_q} : 32'd0;

`ifndef SYNTHESIS
  // a verdict always closes the line
  a_verdict_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_data.last) |=> (phase_q == PH_IDLE))
    else $error("verdict pushed without returning to idle");

  // hold-back line never overfills
  a_hb_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hb_cnt_q <= 3'd4)
    else $error("hold-back count out of range");

  // flush never releases more than was held back
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FLUSH) |-> (fl_left_q <= hb_cnt_q))
    else $error("flush length exceeds hold-back count");

  // queue never takes an item while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fcnt_q == 2'd2) |-> !push)
    else $error("push into full output queue");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import nmea_pkg::*;

  localparam int TALKER_LEN   = 2;
  localparam int SENTENCE_LEN = 3;
  localparam int FIELD_LIMIT  = 32;
  localparam int HDR_LEN      = TALKER_LEN + SENTENCE_LEN;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_BODY,
    LN_DISCARD
  } line_phase_e;

  // one directed line; status is typed in only where it is obvious
  typedef struct {
    string        text;
    bit           typed;
    line_status_e status;
  } line_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] line_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] char_value, [12:8] field_number, [20:13] char_offset, [23:21] line_status,
  // [24] checksum_present, [32:25] computed_checksum, [38:33] field_total, [39] zero
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;           // [1:0] item_kind
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  always #10 clk_i = ~clk_i;

  nmea_sentence_parser_core #(
    .TALKER_LENGTH   (TALKER_LEN),
    .SENTENCE_LENGTH (SENTENCE_LEN),
    .MAX_FIELDS      (FIELD_LIMIT)
  ) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // parser state mirrored by the predictor
  line_phase_e ph = LN_IDLE;
  logic [7:0]  hold_q [4];
  int          held;
  logic [7:0]  run_xor;
  logic [7:0]  pay_count;
  int          hdr_pos;
  int          fld;
  logic [7:0]  fld_off;
  line_status_e line_err;
  logic [7:0]  pay_limit = MAX_PAYLOAD_RESET;

  result_t     expected_items [$];
  logic [7:0]  line_buf [$];
  logic [7:0]  line_xor;
  line_row_t   rows [7];
  int          fail_count = 0;
  bit          calm = 1'b0;
  int          ready_left = 0;
  result_t     want;

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  function automatic int hex_nibble(logic [7:0] c);
    if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
    if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
    if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic result_t mk_item(item_kind_e kind, logic [7:0] ch, logic [4:0] fn,
                                      logic [7:0] off, line_status_e st, logic pres,
                                      logic [7:0] x, logic [5:0] tot);
    result_t r;
    r.kind              = kind;
    r.char_value        = ch;
    r.field_number      = fn;
    r.char_offset       = off;
    r.line_status       = st;
    r.checksum_present  = pres;
    r.computed_checksum = x;
    r.field_total       = tot;
    r.last              = (kind == KIND_VERDICT);
    return r;
  endfunction

  task automatic clear_line();
    foreach (hold_q[i]) hold_q[i] = 8'h00;
    held      = 0;
    run_xor   = 8'h00;
    pay_count = 8'h00;
    hdr_pos   = 0;
    fld       = 0;
    fld_off   = 8'h00;
    line_err  = ST_OK;
  endtask

  // one payload byte: checksum, length check, then header, separator or field char
  task automatic fold_payload(logic [7:0] c);
    run_xor ^= c;
    if (pay_count >= pay_limit && line_err == ST_OK) line_err = ST_TOO_LONG;
    if (pay_count != 8'hFF) pay_count++;
    if (hdr_pos < HDR_LEN) begin
      expected_items.push_back(mk_item(KIND_HEADER, c, 5'd0, 8'(hdr_pos), ST_OK, 1'b0,
                                       8'h00, 6'd0));
      hdr_pos++;
    end else if (c == CH_COMMA) begin
      if (fld + 1 >= FIELD_LIMIT) begin
        if (line_err == ST_OK) line_err = ST_TOO_MANY;
      end else begin
        fld++;
      end
      fld_off = 8'h00;
      expected_items.push_back(mk_item(KIND_SEP, c, 5'(fld), 8'h00, ST_OK, 1'b0,
                                       8'h00, 6'd0));
    end else begin
      expected_items.push_back(mk_item(KIND_FIELD, c, 5'(fld), fld_off, ST_OK, 1'b0,
                                       8'h00, 6'd0));
      if (fld_off != 8'hFF) fld_off++;
    end
  endtask

  // predictor: one accepted line byte in, its results queued
  task automatic parse_line_byte(logic [7:0] c);
    int n;
    int hi;
    int lo;
    bit pres;
    bit ok;
    int tot;
    line_status_e st;
    case (ph)
      LN_IDLE: begin
        if (c == CH_DOLLAR) begin
          clear_line();
          ph = LN_BODY;
        end else if (c == CH_LF) begin
          expected_items.push_back(mk_item(KIND_VERDICT, 8'h00, 5'd0, 8'h00, ST_NO_DOLLAR,
                                           1'b0, 8'h00, 6'd0));
        end else begin
          ph = LN_DISCARD;
        end
      end
      LN_DISCARD: begin
        if (c == CH_LF) begin
          ph = LN_IDLE;
          clear_line();
          expected_items.push_back(mk_item(KIND_VERDICT, 8'h00, 5'd0, 8'h00, ST_NO_DOLLAR,
                                           1'b0, 8'h00, 6'd0));
        end
      end
      default: begin
        if (c != CH_LF) begin
          // four-byte hold-back; the oldest byte leaves as payload
          if (held >= 4) begin
            fold_payload(hold_q[0]);
            hold_q[0] = hold_q[1];
            hold_q[1] = hold_q[2];
            hold_q[2] = hold_q[3];
            hold_q[3] = c;
          end else begin
            hold_q[held] = c;
            held++;
          end
        end else begin
          // end of line: strip trailing cr and star checksum, flush, verdict
          n    = held;
          pres = 1'b0;
          ok   = 1'b1;
          hi   = -1;
          lo   = -1;
          if (n > 0 && hold_q[n-1] == CH_CR) n--;
          if (n >= 3 && hold_q[n-3] == CH_STAR) begin
            pres = 1'b1;
            hi   = hex_nibble(hold_q[n-2]);
            lo   = hex_nibble(hold_q[n-1]);
            n   -= 3;
          end
          for (int i = 0; i < n; i++) fold_payload(hold_q[i]);
          if (pres) ok = (hi >= 0) && (lo >= 0) && ((hi * 16 + lo) == int'(run_xor));
          st  = ok ? line_err : ST_CKS_MISMATCH;
          tot = (pay_count > HDR_LEN) ? fld + 1 : 0;
          expected_items.push_back(mk_item(KIND_VERDICT, 8'h00, 5'd0, 8'h00, st, pres,
                                           run_xor, 6'(tot)));
          ph = LN_IDLE;
          clear_line();
        end
      end
    endcase
  endtask

  // result side: compare each transaction, and random stall bursts on tready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_items.size() == 0) begin
        $error("result transaction with nothing expected: tdata 0x%0h", m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_items.pop_front();
        check_field("item_kind", want.kind, m_axis_tuser);
        check_field("char_value", want.char_value, m_axis_tdata[7:0]);
        check_field("field_number", want.field_number, m_axis_tdata[12:8]);
        check_field("char_offset", want.char_offset, m_axis_tdata[20:13]);
        check_field("line_status", want.line_status, m_axis_tdata[23:21]);
        check_field("checksum_present", want.checksum_present, m_axis_tdata[24]);
        check_field("computed_checksum", want.computed_checksum, m_axis_tdata[32:25]);
        check_field("field_total", want.field_total, m_axis_tdata[38:33]);
        check_field("last", want.last, m_axis_tlast);
      end
    end
    if (ready_left == 0) begin
      if (calm || $urandom_range(0, 2) != 0) begin
        m_axis_tready <= 1'b1;
        ready_left    <= $urandom_range(1, 20);
      end else begin
        m_axis_tready <= 1'b0;
        ready_left    <= $urandom_range(1, 14);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // one byte transaction with an occasional idle burst in front
  task automatic send_byte(logic [7:0] b);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    parse_line_byte(b);
  endtask

  task automatic send_line();
    for (int i = 0; i < line_buf.size(); i++) send_byte(line_buf[i]);
  endtask

  // wait for all results, then let the block settle
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_items.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [7:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pay_limit = v;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic reg_read();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field("max_payload_length", pay_limit, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
    return c;
  endfunction

  function automatic logic [7:0] field_char();
    string pool = "0123456789.NSEW-";
    if ($urandom_range(0, 12) == 0) return noise_byte();
    return pool[$urandom_range(0, 15)];
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  task automatic push_pay(logic [7:0] c);
    line_buf.push_back(c);
    line_xor ^= c;
  endtask

  // random line: mostly well formed, some bad checksums, junk and noise
  task automatic build_line();
    int mode;
    int nf;
    int nc;
    logic [7:0] c;
    logic [7:0] cks;
    mode = $urandom_range(0, 9);
    line_buf.delete();
    line_xor = 8'h00;
    if (mode == 8) begin
      // junk without a leading dollar
      do c = noise_byte(); while (c == CH_DOLLAR);
      line_buf.push_back(c);
      nc = $urandom_range(0, 8);
      for (int i = 0; i < nc; i++) line_buf.push_back(noise_byte());
    end else begin
      line_buf.push_back(CH_DOLLAR);
      if (mode == 9) begin
        nc = $urandom_range(0, 12);
        for (int i = 0; i < nc; i++) push_pay(noise_byte());
      end else begin
        for (int i = 0; i < HDR_LEN; i++) push_pay(8'h41 + 8'($urandom_range(0, 25)));
        nf = $urandom_range(0, 4);
        for (int k = 0; k < nf; k++) begin
          push_pay(CH_COMMA);
          nc = $urandom_range(0, 5);
          for (int i = 0; i < nc; i++) push_pay(field_char());
        end
        if (mode <= 4 || mode == 7) begin
          cks = line_xor;
          if (mode == 7) cks ^= 8'($urandom_range(1, 255));
          line_buf.push_back(CH_STAR);
          line_buf.push_back(hex_char(cks[7:4]));
          line_buf.push_back(hex_char(cks[3:0]));
          // a letter past f is not a hex digit
          if (mode == 7 && $urandom_range(0, 1) == 1)
            line_buf[line_buf.size() - 1 - $urandom_range(0, 1)] =
              8'h47 + 8'($urandom_range(0, 19));
        end
      end
      if ($urandom_range(0, 1) == 1) line_buf.push_back(CH_CR);
    end
    line_buf.push_back(CH_LF);
  endtask

  // header followed by a given number of commas
  task automatic build_commas(int n);
    line_buf.delete();
    line_buf.push_back(CH_DOLLAR);
    for (int i = 0; i < HDR_LEN; i++) line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
    for (int i = 0; i < n; i++) begin
      line_buf.push_back(CH_COMMA);
      if ($urandom_range(0, 1) == 1) line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end
    line_buf.push_back(CH_LF);
  endtask

  // payload of an exact length, digits and commas only past the header
  task automatic build_sized(int len, bit one_field);
    line_buf.delete();
    line_buf.push_back(CH_DOLLAR);
    for (int i = 0; i < len; i++) begin
      if (i < HDR_LEN) line_buf.push_back(8'h41 + 8'($urandom_range(0, 25)));
      else if (i == HDR_LEN || (!one_field && i % 7 == 0)) line_buf.push_back(CH_COMMA);
      else line_buf.push_back(8'h30 + 8'(i % 10));
    end
    line_buf.push_back(CH_LF);
  endtask

  initial begin
    int lims [5];
    int sent;
    logic [7:0] b;
    result_t r;
    lims = '{255, 1, 0, 0, 80};
    lims[3] = $urandom_range(6, 20);
    clear_line();

    // '^' in a row stands for a zero byte
    rows[0] = '{"\n", 1'b1, ST_NO_DOLLAR};
    rows[1] = '{"x\n", 1'b1, ST_NO_DOLLAR};
    rows[2] = '{"$\n", 1'b0, ST_OK};
    rows[3] = '{"$A*41\n", 1'b1, ST_OK};
    rows[4] = '{"$j*6a\015\n", 1'b1, ST_OK};
    rows[5] = '{"$A*ZZ\n", 1'b1, ST_CKS_MISMATCH};
    rows[6] = '{"$GPGGA,*,\015^\377\n", 1'b0, ST_OK};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    reg_read();

    // directed lines at the reset limit
    for (int i = 0; i < 7; i++) begin
      for (int j = 0; j < rows[i].text.len(); j++) begin
        b = rows[i].text[j];
        if (b == "^") b = 8'h00;
        send_byte(b);
      end
      if (rows[i].typed) begin
        r = expected_items.pop_back();
        r.line_status = rows[i].status;
        expected_items.push_back(r);
      end
    end

    // random lines under several limits, the last part without idling
    for (int p = 0; p < 5; p++) begin
      settle();
      reg_write(8'(lims[p]));
      reg_read();
      calm = (p == 4);
      if (p == 0) begin
        build_commas(FIELD_LIMIT - 1);
        send_line();
        build_commas(FIELD_LIMIT + 1);
        send_line();
      end
      if (p == 3) begin
        build_sized(lims[p], 1'b0);
        send_line();
        build_sized(lims[p] + 1, 1'b0);
        send_line();
      end
      sent = 0;
      while (sent < 10) begin
        build_line();
        sent += line_buf.size();
        send_line();
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
